/* hdl/mktt_pkg.sv */
// ----------------------------------------------------------------------------
// mktt_pkg: shared types and constants of the trust table
// Item layouts, kind and status codes, sequencer states.
// ----------------------------------------------------------------------------
package mktt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [2:0] KindAdd    = 3'd0;
  localparam logic [2:0] KindRemove = 3'd1;
  localparam logic [2:0] KindHeader = 3'd2;
  localparam logic [2:0] KindEntry  = 3'd3;
  localparam logic [2:0] KindEnd    = 3'd4;
  localparam logic [2:0] KindList   = 3'd5;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StDup      = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StRejected = 3'd4;
  localparam logic [2:0] StIgnored  = 3'd5;

  localparam logic [1:0] RegOwnUid    = 2'd0;
  localparam logic [1:0] RegOwnMac    = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;
  localparam logic [1:0] RegRespType  = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [47:0]        peer_mac;
    logic [7:0]         peer_uid;
    logic signed [15:0] peer_trust;
    logic [3:0]         entry_position;
    logic [7:0]         msg_type;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               entry_valid;
    logic [7:0]         entry_uid;
    logic [47:0]        entry_mac;
    logic signed [15:0] entry_trust;
    logic               urgent;
    logic [4:0]         peer_count;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_SCAN,
    S_SHIFT,
    S_RUN,
    S_OUT
  } state_e;

endpackage

/* hdl/mktt_if.sv */
// ----------------------------------------------------------------------------
// mktt_if: valid/ready channel
// Carries one item of type T per handshake.
// ----------------------------------------------------------------------------
interface mktt_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/mac_keyed_trust_table_unit.sv */
// ----------------------------------------------------------------------------
// mac_keyed_trust_table_unit: MAC-keyed peer table with trust updates
// Add, remove, trust update responses and listing over a packed table.
// ----------------------------------------------------------------------------
// Header and unused kinds are answered from S_OUT; lookups compare one entry
// per cycle while the output register is free, removal shifts the following
// entries down one by one; runs give one item per cycle unless output stalls.
// Throughput: one item at a time; ready only in idle.
// Reset: async, active low; clears count, flags, state and config registers;
// table, held item and output data are not cleared.
module mac_keyed_trust_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  mktt_if.sink        in_if,
  mktt_if.source      out_if
);

  localparam int unsigned IW = mktt_pkg::IdxW;
  localparam int unsigned CW = mktt_pkg::CntW;

  logic [7:0]         own_uid_q;
  logic [47:0]        own_mac_q;
  logic signed [15:0] thr_q;
  logic [7:0]         rtype_q;

  logic [7:0]         uid_mem [mktt_pkg::TableDepth];
  logic [47:0]        mac_mem [mktt_pkg::TableDepth];
  logic signed [15:0] tr_mem  [mktt_pkg::TableDepth];

  mktt_pkg::state_e    state_q, state_d;
  mktt_pkg::in_item_t  it_q;
  mktt_pkg::out_item_t out_q, out_d;
  logic [CW-1:0] cnt_q, cnt_d, ptr_q, ptr_d;
  logic urg_q, urg_d, open_q, open_d, ovld_q, ovld_d;

  // write port
  logic              we;
  logic [IW-1:0]     wa;
  logic [7:0]        wuid;
  logic [47:0]       wmac;
  logic signed [15:0] wtr;

  logic [IW-1:0] rp;
  logic          hit;
  logic [IW-1:0] pos_idx;
  logic          pos_ok;

  assign rp      = ptr_q[IW-1:0];
  assign hit     = (mac_mem[rp] == it_q.peer_mac);
  assign pos_ok  = ({1'b0, it_q.entry_position} < 5'(cnt_q))
                   && (32'(it_q.entry_position) < mktt_pkg::TableDepth);
  assign pos_idx = IW'(it_q.entry_position);

  assign in_if.ready  = (state_q == mktt_pkg::S_IDLE);
  assign out_if.valid = ovld_q;
  assign out_if.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_uid_q <= '0;
      own_mac_q <= '0;
      thr_q     <= '0;
      rtype_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mktt_pkg::RegOwnUid:    own_uid_q <= cfg_data_i[7:0];
        mktt_pkg::RegOwnMac:    own_mac_q <= cfg_data_i;
        mktt_pkg::RegThreshold: thr_q     <= cfg_data_i[15:0];
        mktt_pkg::RegRespType:  rtype_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mktt_pkg::S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      urg_q   <= 1'b0;
      open_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      urg_q   <= urg_d;
      open_q  <= open_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_if.valid && in_if.ready) begin
      it_q <= in_if.data;
    end
    if (we) begin
      uid_mem[wa] <= wuid;
      mac_mem[wa] <= wmac;
      tr_mem[wa]  <= wtr;
    end
  end

  always_comb begin
    mktt_pkg::out_item_t o;
    logic [IW-1:0] nx;
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    urg_d   = urg_q;
    open_d  = open_q;
    ovld_d  = ovld_q;
    out_d   = out_q;
    we      = 1'b0;
    wa      = rp;
    wuid    = uid_mem[rp];
    wmac    = mac_mem[rp];
    wtr     = it_q.peer_trust;
    nx      = IW'(ptr_q + 1'b1);
    o       = '0;
    o.urgent     = urg_q;
    o.peer_count = 5'(cnt_q);
    o.last       = 1'b1;
    if (ovld_q && out_if.ready) begin
      ovld_d = 1'b0;
    end
    case (state_q)
      mktt_pkg::S_IDLE: begin
        ptr_d = '0;
        if (in_if.valid) begin
          case (in_if.data.kind)
            mktt_pkg::KindAdd, mktt_pkg::KindRemove: state_d = mktt_pkg::S_SCAN;
            mktt_pkg::KindEntry:
              state_d = open_q ? mktt_pkg::S_POS : mktt_pkg::S_OUT;
            mktt_pkg::KindEnd: begin
              if (open_q) begin
                open_d  = 1'b0;
                state_d = mktt_pkg::S_RUN;
              end else begin
                state_d = mktt_pkg::S_OUT;
              end
            end
            mktt_pkg::KindList: state_d = mktt_pkg::S_RUN;
            default: state_d = mktt_pkg::S_OUT;
          endcase
        end
      end
      mktt_pkg::S_POS: begin
        ptr_d   = '0;
        state_d = mktt_pkg::S_SCAN;
        if (pos_ok && mac_mem[pos_idx] == it_q.peer_mac) begin
          ptr_d   = CW'(pos_idx);
          state_d = mktt_pkg::S_SCAN;
        end
      end
      mktt_pkg::S_SCAN: begin
        if (ptr_q >= cnt_q) begin
          // not found
          if (it_q.kind == mktt_pkg::KindAdd) begin
            if (32'(cnt_q) >= mktt_pkg::TableDepth) begin
              o.status = mktt_pkg::StFull;
            end else begin
              we   = 1'b1;
              wa   = IW'(cnt_q);
              wuid = it_q.peer_uid;
              wmac = it_q.peer_mac;
              cnt_d = cnt_q + 1'b1;
              o.peer_count = 5'(cnt_q + 1'b1);
            end
          end else begin
            o.status = mktt_pkg::StNotFound;
          end
          out_d   = o;
          ovld_d  = 1'b1;
          state_d = mktt_pkg::S_IDLE;
        end else if (hit) begin
          case (it_q.kind)
            mktt_pkg::KindAdd: begin
              o.status = mktt_pkg::StDup;
              out_d    = o;
              ovld_d   = 1'b1;
              state_d  = mktt_pkg::S_IDLE;
            end
            mktt_pkg::KindRemove: state_d = mktt_pkg::S_SHIFT;
            default: begin
              we = 1'b1;
              if ((tr_mem[rp] >= thr_q) != (it_q.peer_trust >= thr_q)) begin
                urg_d    = 1'b1;
                o.urgent = 1'b1;
              end
              out_d   = o;
              ovld_d  = 1'b1;
              state_d = mktt_pkg::S_IDLE;
            end
          endcase
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      mktt_pkg::S_SHIFT: begin
        if (ptr_q + 1'b1 < cnt_q) begin
          we    = 1'b1;
          wuid  = uid_mem[nx];
          wmac  = mac_mem[nx];
          wtr   = tr_mem[nx];
          ptr_d = ptr_q + 1'b1;
        end else begin
          cnt_d        = cnt_q - 1'b1;
          o.peer_count = 5'(cnt_q - 1'b1);
          out_d        = o;
          ovld_d       = 1'b1;
          state_d      = mktt_pkg::S_IDLE;
        end
      end
      mktt_pkg::S_RUN: begin
        if (!ovld_q || out_if.ready) begin
          if (cnt_q == '0) begin
            out_d   = o;
            ovld_d  = 1'b1;
            state_d = mktt_pkg::S_IDLE;
          end else begin
            o.entry_valid = 1'b1;
            o.entry_uid   = uid_mem[rp];
            o.entry_mac   = mac_mem[rp];
            o.entry_trust = tr_mem[rp];
            o.last        = (ptr_q + 1'b1 == cnt_q);
            out_d  = o;
            ovld_d = 1'b1;
            ptr_d  = ptr_q + 1'b1;
            if (o.last) begin
              state_d = mktt_pkg::S_IDLE;
            end
          end
        end
      end
      mktt_pkg::S_OUT: begin
        if (it_q.kind == mktt_pkg::KindHeader) begin
          if (it_q.msg_type == rtype_q && it_q.peer_uid == own_uid_q
              && it_q.peer_mac == own_mac_q) begin
            urg_d    = 1'b0;
            o.urgent = 1'b0;
            open_d   = 1'b1;
          end else begin
            open_d   = 1'b0;
            o.status = mktt_pkg::StRejected;
          end
        end else begin
          o.status = mktt_pkg::StIgnored;
        end
        out_d   = o;
        ovld_d  = 1'b1;
        state_d = mktt_pkg::S_IDLE;
      end
      default: state_d = mktt_pkg::S_IDLE;
    endcase
    // idle only once the output register is free
    if (state_q != mktt_pkg::S_IDLE && state_q != mktt_pkg::S_RUN
        && ovld_q && !out_if.ready) begin
      state_d = state_q;
      cnt_d   = cnt_q;
      ptr_d   = ptr_q;
      urg_d   = urg_q;
      open_d  = open_q;
      ovld_d  = ovld_q;
      out_d   = out_q;
      we      = 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= mktt_pkg::TableDepth) else $error("count overflow");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mktt_pkg::S_IDLE) |-> !in_if.ready) else $error("ready while busy");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1
      || cnt_q == $past(cnt_q) - 1'b1)) else $error("count jump");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid) else $error("item dropped");
`endif

endmodule
